FILE: rtl/core/itda_pkg.sv
// ----------------------------------------------------------------------------
// itda_pkg
// Shared types and constants for the integer to decimal ASCII converter.
// ----------------------------------------------------------------------------
package itda_pkg;

  localparam int unsigned FieldW = 64;

  localparam logic [5:0] CharZero  = 6'd48;
  localparam logic [5:0] CharMinus = 6'd45;

  localparam logic KindSigned   = 1'b0;
  localparam logic KindUnsigned = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [FieldW-1:0] value;
  } in_t;

  typedef struct packed {
    logic [5:0] character;
    logic       last;
  } out_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic dabble;
    logic emit_sign;
    logic emit_digit;
    logic last_digit;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic negative;
  } sts_t;

endpackage

FILE: rtl/core/itda_ctrl.sv
// ----------------------------------------------------------------------------
// itda_ctrl
// Sequencer: load, shift-add-3 conversion, optional sign, digit sweep.
// ----------------------------------------------------------------------------
module itda_ctrl #(
  parameter int unsigned VALUE_WIDTH = 64,
  parameter int unsigned NumDigits   = 20
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  itda_pkg::sts_t sts_i,
  output itda_pkg::cmd_t cmd_o
);

  localparam int unsigned CntW = $clog2(VALUE_WIDTH);
  localparam logic [CntW-1:0] ConvLast  = CntW'(VALUE_WIDTH - 1);
  localparam logic [CntW-1:0] DigitLast = CntW'(NumDigits - 1);

  typedef enum logic [1:0] {
    StIdle,
    StConv,
    StSign,
    StEmit
  } state_e;

  state_e          state_q;
  logic [CntW-1:0] cnt_q;

  assign busy_o = (state_q != StIdle);

  always_comb begin
    cmd_o            = '0;
    cmd_o.load       = (state_q == StIdle) && start_i;
    cmd_o.dabble     = (state_q == StConv);
    cmd_o.emit_sign  = (state_q == StSign);
    cmd_o.emit_digit = (state_q == StEmit);
    cmd_o.last_digit = (state_q == StEmit) && (cnt_q == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        StIdle: begin
          if (start_i) begin
            state_q <= StConv;
            cnt_q   <= '0;
          end
        end
        StConv: begin
          if (cnt_q == ConvLast) begin
            state_q <= sts_i.negative ? StSign : StEmit;
            cnt_q   <= DigitLast;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        StSign: begin
          state_q <= StEmit;
        end
        StEmit: begin
          if (cnt_q == '0) begin
            state_q <= StIdle;
          end else begin
            cnt_q <= cnt_q - 1'b1;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

endmodule

FILE: rtl/core/itda_dpath.sv
// ----------------------------------------------------------------------------
// itda_dpath
// Magnitude register, BCD shift-add-3 converter and output character register.
// ----------------------------------------------------------------------------
module itda_dpath #(
  parameter int unsigned VALUE_WIDTH = 64,
  parameter int unsigned NumDigits   = 20
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  itda_pkg::in_t  item_i,
  input  itda_pkg::cmd_t cmd_i,
  output itda_pkg::sts_t sts_o,
  output logic           res_strobe_o,
  output itda_pkg::out_t res_o
);

  localparam int unsigned BcdW = 4 * NumDigits;

  logic [VALUE_WIDTH-1:0] bin_q, bin_d, raw;
  logic [BcdW-1:0]        bcd_q, bcd_d, adj;
  logic                   neg_q, neg_d;
  logic                   started_q, started_d;
  logic                   strobe_q, strobe_d;
  itda_pkg::out_t         res_q, res_d;
  logic [3:0]             top_digit;

  assign raw       = item_i.value[VALUE_WIDTH-1:0];
  assign top_digit = bcd_q[BcdW-1 -: 4];

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3
                                                  : bcd_q[4*i +: 4];
    end
  end

  always_comb begin
    bin_d     = bin_q;
    bcd_d     = bcd_q;
    neg_d     = neg_q;
    started_d = started_q;
    strobe_d  = 1'b0;
    res_d     = res_q;
    if (cmd_i.load) begin
      neg_d     = (item_i.kind == itda_pkg::KindSigned) && raw[VALUE_WIDTH-1];
      bin_d     = neg_d ? (~raw + 1'b1) : raw;
      bcd_d     = '0;
      started_d = 1'b0;
    end
    if (cmd_i.dabble) begin
      bcd_d = {adj[BcdW-2:0], bin_q[VALUE_WIDTH-1]};
      bin_d = {bin_q[VALUE_WIDTH-2:0], 1'b0};
    end
    if (cmd_i.emit_sign) begin
      strobe_d        = 1'b1;
      res_d.character = itda_pkg::CharMinus;
      res_d.last      = 1'b0;
    end
    if (cmd_i.emit_digit) begin
      bcd_d = {bcd_q[BcdW-5:0], 4'd0};
      // leading zeros are dropped, the units digit always goes out
      if (started_q || (top_digit != 4'd0) || cmd_i.last_digit) begin
        started_d       = 1'b1;
        strobe_d        = 1'b1;
        res_d.character = itda_pkg::CharZero + {2'b00, top_digit};
        res_d.last      = cmd_i.last_digit;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q     <= bin_d;
    bcd_q     <= bcd_d;
    neg_q     <= neg_d;
    started_q <= started_d;
    res_q     <= res_d;
  end

  assign sts_o.negative = neg_q;
  assign res_strobe_o   = strobe_q;
  assign res_o          = res_q;

endmodule

FILE: rtl/core/int_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// int_to_decimal_ascii
// Integer to decimal ASCII text, one character per result beat.
// ----------------------------------------------------------------------------
// Input: item_i (kind, value) is taken at a clock edge where start_i is high
// and busy_o is low. kind = 0 reads the low VALUE_WIDTH bits as two's
// complement, kind = 1 as unsigned; higher bits are ignored.
// Output: one character per beat on res_o, flagged by res_strobe_o for exactly
// one cycle; the most significant character comes first, res_o.last marks the
// final one. A negative value starts with '-'. Zero gives a single '0'.
// Sequence: the magnitude runs through a shift-add-3 BCD converter, one bit a
// cycle, then an optional sign step, then a sweep over the ND digits (ND = 20
// at 64 bits) that drops leading zeros. busy_o stays high from the accept until
// the sweep ends, and a new item is taken only once busy_o is low again.
// The last character shows in the first cycle busy_o is low again.
// Reset clears the sequencer and the strobe; no beat follows reset. The
// receiver has no way to stall, and needs none.
// ----------------------------------------------------------------------------
module int_to_decimal_ascii #(
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  output logic           busy_o,
  input  itda_pkg::in_t  item_i,
  output logic           res_strobe_o,
  output itda_pkg::out_t res_o
);

  // digits of 2^W - 1: floor(W * log10(2)) + 1
  localparam int unsigned NumDigits = (VALUE_WIDTH * 30103) / 100000 + 1;

  itda_pkg::cmd_t cmd;
  itda_pkg::sts_t sts;

  itda_ctrl #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .NumDigits   (NumDigits)
  ) u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .sts_i   (sts),
    .cmd_o   (cmd)
  );

  itda_dpath #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .NumDigits   (NumDigits)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (item_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .res_strobe_o (res_strobe_o),
    .res_o        (res_o)
  );

endmodule

FILE: rtl/core/itda_checker.sv
// ----------------------------------------------------------------------------
// itda_assert
// Port-level checks on the converter's command and result beats.
// ----------------------------------------------------------------------------
module itda_assert (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start_i,
  input logic           busy_i,
  input logic           res_strobe_i,
  input itda_pkg::out_t res_i
);

  // an accept makes the block busy and no beat follows right away
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_i) |=> (busy_i && !res_strobe_i))
    else $error("accept not followed by busy");

  // characters are '-' or a digit
  a_char_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_i |-> ((res_i.character == itda_pkg::CharMinus) ||
                      ((res_i.character >= itda_pkg::CharZero) &&
                       (res_i.character <= 6'd57))))
    else $error("character out of range");

  // the final character is shown once the block is free again
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_strobe_i && res_i.last) |-> !busy_i)
    else $error("last beat while still busy");

  // a sign is never the final character
  a_sign_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_strobe_i && (res_i.character == itda_pkg::CharMinus)) |-> !res_i.last)
    else $error("sign marked as last");

  // every beat comes out of work started earlier
  a_beat_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_i |-> $past(busy_i))
    else $error("beat without work in flight");

endmodule

bind int_to_decimal_ascii itda_assert u_itda_assert (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start_i      (start_i),
  .busy_i       (busy_o),
  .res_strobe_i (res_strobe_o),
  .res_i        (res_o)
);
